[rtl/windowed_touch_edge_detector_defines.svh]
// Assertion macros for the edge detector checker.
`ifndef WINDOWED_TOUCH_EDGE_DETECTOR_DEFINES_SVH
`define WINDOWED_TOUCH_EDGE_DETECTOR_DEFINES_SVH
`define WTED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define WTED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[rtl/wted_pkg.sv]
package wted_pkg;
  localparam int SampleW = 16;
  localparam int LevelW  = 15;
  localparam int ModeW   = 3;
  localparam int CmdW    = 4;
  localparam logic signed [SampleW-1:0] FillMin = 16'sd11;
  localparam logic [ModeW-1:0] ModeIdle  = 3'd0;
  localparam logic [ModeW-1:0] ModeHeld  = 3'd1;
  localparam logic [ModeW-1:0] ModePlace = 3'd2;
  localparam logic [ModeW-1:0] ModeRel   = 3'd3;
  localparam logic [ModeW-1:0] ModePush  = 3'd6;
  localparam logic [ModeW-1:0] ModeWait  = 3'd7;
  localparam logic [CmdW-1:0] CmdNone    = 4'd0;
  localparam logic [CmdW-1:0] CmdGrasp   = 4'd1;
  localparam logic [CmdW-1:0] CmdRelease = 4'd3;
  localparam logic [CmdW-1:0] CmdLeft    = 4'd7;
  localparam logic [CmdW-1:0] CmdRight   = 4'd8;
  localparam logic [1:0] RegLow  = 2'd0;
  localparam logic [1:0] RegHigh = 2'd1;
  localparam logic [1:0] RegEdge = 2'd2;
  localparam logic [1:0] RegMode = 2'd3;

  typedef struct packed {
    logic clear;
    logic scan;
  } cmd_t;
endpackage

[rtl/wted_datapath.sv]
module wted_datapath #(
  parameter int HALF_WINDOW = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic signed [wted_pkg::SampleW-1:0] sample_main_i,
  input  logic signed [wted_pkg::SampleW-1:0] sample_left_i,
  input  logic signed [wted_pkg::SampleW-1:0] sample_right_i,
  input  logic [wted_pkg::LevelW-1:0] high_level_i,
  input  wted_pkg::cmd_t cmd_i,
  output logic signed [wted_pkg::SampleW-1:0] oldest_main_o,
  output logic signed [wted_pkg::SampleW-1:0] last_left_o,
  output logic signed [wted_pkg::SampleW-1:0] last_right_o,
  output logic signed [wted_pkg::SampleW-1:0] mx_o [3],
  output logic signed [wted_pkg::SampleW-1:0] mn_o [3],
  output logic signed [wted_pkg::SampleW+7:0] older_o,
  output logic signed [wted_pkg::SampleW+7:0] newer_o [3],
  output logic [7:0] above_o
);
  import wted_pkg::*;
  localparam int WinLen = 2 * HALF_WINDOW;
  localparam int IdxW = $clog2(WinLen);
  localparam int SumW = SampleW + 8;

  logic signed [SampleW-1:0] win_q [3][WinLen];
  logic [IdxW-1:0] idx_q;
  logic signed [SampleW-1:0] s_cur [3];
  logic signed [SampleW-1:0] s_new [3];

  assign s_new[0] = sample_main_i;
  assign s_new[1] = sample_left_i;
  assign s_new[2] = sample_right_i;
  assign oldest_main_o = win_q[0][0];
  assign last_left_o = win_q[1][WinLen-1];
  assign last_right_o = win_q[2][WinLen-1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s_cur[c] = win_q[c][idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < WinLen; k++) begin
          win_q[c][k] <= '0;
        end
      end
    end else if (shift_i) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < WinLen - 1; k++) begin
          win_q[c][k] <= win_q[c][k+1];
        end
        win_q[c][WinLen-1] <= s_new[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.clear) begin
      idx_q <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // The clear coincides with the shift, so entry 1 is the oldest sample of the new window.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      for (int c = 0; c < 3; c++) begin
        mx_o[c] <= win_q[c][1];
        mn_o[c] <= win_q[c][1];
        newer_o[c] <= '0;
      end
      older_o <= '0;
      above_o <= '0;
    end else if (cmd_i.scan) begin
      for (int c = 0; c < 3; c++) begin
        if (s_cur[c] > mx_o[c]) mx_o[c] <= s_cur[c];
        if (s_cur[c] < mn_o[c]) mn_o[c] <= s_cur[c];
        if (32'(idx_q) >= HALF_WINDOW) newer_o[c] <= newer_o[c] + SumW'(s_cur[c]);
      end
      if (32'(idx_q) < HALF_WINDOW) older_o <= older_o + SumW'(s_cur[0]);
      if (s_cur[0] > $signed({1'b0, high_level_i})) above_o <= above_o + 8'd1;
    end
  end
endmodule

[rtl/wted_ctrl.sv]
module wted_ctrl #(
  parameter int HALF_WINDOW = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  logic at_place_pos_i,
  input  logic at_home_pos_i,
  input  logic [wted_pkg::LevelW-1:0] low_level_i,
  input  logic [wted_pkg::LevelW-1:0] high_level_i,
  input  logic [wted_pkg::LevelW-1:0] edge_width_i,
  input  logic mode_load_i,
  input  logic mode_push_i,
  input  logic signed [wted_pkg::SampleW-1:0] oldest_main_i,
  input  logic signed [wted_pkg::SampleW-1:0] last_left_i,
  input  logic signed [wted_pkg::SampleW-1:0] last_right_i,
  input  logic signed [wted_pkg::SampleW-1:0] mx_i [3],
  input  logic signed [wted_pkg::SampleW-1:0] mn_i [3],
  input  logic signed [wted_pkg::SampleW+7:0] older_i,
  input  logic signed [wted_pkg::SampleW+7:0] newer_i [3],
  input  logic [7:0] above_i,
  output logic shift_o,
  output wted_pkg::cmd_t cmd_o,
  output logic [wted_pkg::ModeW-1:0] mode_now_o,
  output logic cmd_valid_o,
  output logic [wted_pkg::CmdW-1:0] cmd_code_o,
  output logic window_ready_o
);
  import wted_pkg::*;
  localparam int WinLen = 2 * HALF_WINDOW;
  localparam int CntW = $clog2(WinLen + 1);
  localparam int W = 40;

  typedef enum logic [1:0] {StIdle, StScan, StDecide, StOut} state_e;
  state_e state_q;
  logic [CntW-1:0] cnt_q;
  logic [ModeW-1:0] mode_q;
  logic rest_known_q, rest_high_q, rise_q, fall_q;
  logic [31:0] item_q, mark_q;
  logic place_q, home_q;

  logic signed [W-1:0] e, span, hdiff, rest, dev, tot, hw_hi, hw_lo;
  logic rest_high_now;
  logic [ModeW-1:0] m_d;
  logic [CmdW-1:0] c_d;
  logic [31:0] mk_d;
  logic rs_d, fs_d;
  logic edge_r, edge_l, pick_any;
  logic [CmdW-1:0] pick;

  function automatic logic signed [W-1:0] sabs(input logic signed [W-1:0] v);
    return v < 0 ? -v : v;
  endfunction

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign shift_o = in_valid_i && (state_q == StIdle);
  assign cmd_o.clear = shift_o;
  assign cmd_o.scan = (state_q == StScan);

  always_comb begin
    logic signed [W-1:0] fm_r, fn_r, bg_r, fm_l, fn_l, bg_l;
    e = W'(signed'({1'b0, edge_width_i}));
    span = W'(mx_i[0]) - W'(mn_i[0]);
    hdiff = sabs(W'(newer_i[0]) - W'(older_i));
    rest_high_now = rest_known_q ? rest_high_q : (32'(above_i) > HALF_WINDOW);
    rest = rest_high_now ? W'(signed'({1'b0, high_level_i}))
                         : W'(signed'({1'b0, low_level_i}));
    tot = W'(older_i) + W'(newer_i[0]);
    dev = sabs(tot - W'(2 * HALF_WINDOW) * rest);
    hw_hi = W'(HALF_WINDOW) * W'(signed'({1'b0, high_level_i}));
    hw_lo = W'(HALF_WINDOW) * W'(signed'({1'b0, low_level_i}));
    m_d = mode_q;
    c_d = CmdNone;
    mk_d = mark_q;
    rs_d = rise_q;
    fs_d = fall_q;
    fm_r = W'(mx_i[2]) - W'(last_right_i);
    fn_r = W'(last_right_i) - W'(mn_i[2]);
    bg_r = fm_r > fn_r ? fm_r : fn_r;
    fm_l = W'(mx_i[1]) - W'(last_left_i);
    fn_l = W'(last_left_i) - W'(mn_i[1]);
    bg_l = fm_l > fn_l ? fm_l : fn_l;
    edge_r = bg_r > e;
    edge_l = bg_l > e;
    pick_any = 1'b0;
    pick = CmdNone;
    if (m_d == ModeIdle) begin
      if (dev < W'(2048 * HALF_WINDOW) && span > e && hdiff > W'(HALF_WINDOW) * e) begin
        m_d = ModeHeld;
        c_d = CmdGrasp;
      end
    end
    if (place_q && m_d == ModeHeld) begin
      m_d = ModePlace;
      mk_d = item_q;
    end
    if (m_d == ModePlace) begin
      if (2 * span > e && 2 * hdiff > W'(HALF_WINDOW) * e &&
          (item_q - mk_d) > 32'(WinLen)) begin
        m_d = ModeRel;
        c_d = CmdRelease;
        mk_d = item_q;
      end
    end
    if (m_d == ModeRel) begin
      if (home_q && (item_q - mk_d) > 32'(WinLen)) m_d = ModeIdle;
    end
    if (m_d == ModePush) begin
      if (edge_r) begin
        pick = CmdRight;
        if (W'(newer_i[2]) > hw_hi && fn_r > e) rs_d = 1'b1;
        else if (W'(newer_i[2]) < hw_lo && fm_r > e) fs_d = 1'b1;
      end else if (edge_l) begin
        pick = CmdLeft;
        if (W'(newer_i[1]) > hw_hi && fn_l > e) rs_d = 1'b1;
        else if (W'(newer_i[1]) < hw_lo && fm_l > e) fs_d = 1'b1;
      end
      pick_any = (pick != CmdNone);
      if (pick_any && (rs_d != fs_d)) begin
        c_d = pick;
        mk_d = item_q;
      end
      if (rs_d == fs_d) m_d = ModeWait;
    end
    if (m_d == ModeWait && (item_q - mk_d) > 32'(HALF_WINDOW)) begin
      rs_d = 1'b0;
      fs_d = 1'b0;
      m_d = ModePush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      mode_q <= ModePush;
      rest_known_q <= 1'b0;
      rest_high_q <= 1'b0;
      rise_q <= 1'b0;
      fall_q <= 1'b0;
      item_q <= '0;
      mark_q <= '0;
      place_q <= 1'b0;
      home_q <= 1'b0;
      mode_now_o <= ModePush;
      cmd_valid_o <= 1'b0;
      cmd_code_o <= CmdNone;
      window_ready_o <= 1'b0;
    end else begin
      if (mode_load_i && !rest_known_q) mode_q <= mode_push_i ? ModePush : ModeIdle;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            place_q <= at_place_pos_i;
            home_q <= at_home_pos_i;
            cnt_q <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(WinLen - 1)) state_q <= StDecide;
        end
        StDecide: begin
          if (oldest_main_i < FillMin) begin
            mode_now_o <= mode_q;
            cmd_valid_o <= 1'b0;
            cmd_code_o <= CmdNone;
            window_ready_o <= 1'b0;
          end else begin
            rest_known_q <= 1'b1;
            rest_high_q <= rest_high_now;
            mode_q <= m_d;
            mark_q <= mk_d;
            rise_q <= rs_d;
            fall_q <= fs_d;
            item_q <= item_q + 32'd1;
            mode_now_o <= m_d;
            cmd_valid_o <= (c_d != CmdNone);
            cmd_code_o <= c_d;
            window_ready_o <= 1'b1;
          end
          state_q <= StOut;
        end
        StOut: begin
          if (!out_stall_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

[rtl/windowed_touch_edge_detector.sv]
// Each accepted item shifts one sample into each of three 2*HALF_WINDOW
// sample windows, then a scan over the windows, one entry a cycle, gathers
// max, min, half sums and the rest-level count, and a decision state steps
// the mode machine once the oldest main sample reaches FillMin. The result
// is registered in the decision state and held valid in the output state
// until the output is not stalled; the next item is taken only after the
// result has gone, back in the idle state, so the block does not take a new
// item while one is still in flight.
module windowed_touch_edge_detector #(
  parameter int HALF_WINDOW = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [wted_pkg::SampleW-1:0] sample_main_i,
  input  logic signed [wted_pkg::SampleW-1:0] sample_left_i,
  input  logic signed [wted_pkg::SampleW-1:0] sample_right_i,
  input  logic at_place_pos_i,
  input  logic at_home_pos_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [wted_pkg::ModeW-1:0] mode_now_o,
  output logic cmd_valid_o,
  output logic [wted_pkg::CmdW-1:0] cmd_code_o,
  output logic window_ready_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import wted_pkg::*;

  logic [LevelW-1:0] low_q, high_q, edge_q;
  logic push_q, wr, mode_load;
  logic [1:0] ridx;
  logic shift;
  cmd_t cmd;
  logic signed [SampleW-1:0] oldest, ll, lr;
  logic signed [SampleW-1:0] mx [3];
  logic signed [SampleW-1:0] mn [3];
  logic signed [SampleW+7:0] older;
  logic signed [SampleW+7:0] newer [3];
  logic [7:0] above;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[3:2];
  assign mode_load = wr && ridx == RegMode && paddr[1:0] == 2'b00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= 15'd1024;
      high_q <= 15'd3072;
      edge_q <= 15'd2048;
      push_q <= 1'b1;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (ridx)
        RegLow:  low_q <= pwdata[LevelW-1:0];
        RegHigh: high_q <= pwdata[LevelW-1:0];
        RegEdge: edge_q <= pwdata[LevelW-1:0];
        RegMode: push_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (ridx)
        RegLow:  prdata = {17'd0, low_q};
        RegHigh: prdata = {17'd0, high_q};
        RegEdge: prdata = {17'd0, edge_q};
        RegMode: prdata = {31'd0, push_q};
        default: prdata = '0;
      endcase
    end
  end

  wted_datapath #(.HALF_WINDOW(HALF_WINDOW)) u_dp (
    .clk_i, .rst_ni, .shift_i(shift), .sample_main_i, .sample_left_i, .sample_right_i,
    .high_level_i(high_q), .cmd_i(cmd), .oldest_main_o(oldest),
    .last_left_o(ll), .last_right_o(lr), .mx_o(mx), .mn_o(mn), .older_o(older),
    .newer_o(newer), .above_o(above)
  );

  wted_ctrl #(.HALF_WINDOW(HALF_WINDOW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .at_place_pos_i, .at_home_pos_i, .low_level_i(low_q), .high_level_i(high_q),
    .edge_width_i(edge_q), .mode_load_i(mode_load), .mode_push_i(pwdata[0]),
    .oldest_main_i(oldest), .last_left_i(ll), .last_right_i(lr),
    .mx_i(mx), .mn_i(mn), .older_i(older), .newer_i(newer), .above_i(above),
    .shift_o(shift), .cmd_o(cmd), .mode_now_o, .cmd_valid_o, .cmd_code_o,
    .window_ready_o
  );
endmodule

[rtl/wted_checker.sv]
`include "windowed_touch_edge_detector_defines.svh"
module wted_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic cmd_valid_o,
  input logic [3:0] cmd_code_o,
  input logic window_ready_o
);
  `WTED_ASSERT_IMPL(a_no_cmd_code, clk_i, rst_ni, out_valid_o && !cmd_valid_o, cmd_code_o == 4'd0)
  `WTED_ASSERT_IMPL(a_cmd_ready, clk_i, rst_ni, out_valid_o && cmd_valid_o, window_ready_o)
  `WTED_ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  `WTED_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `WTED_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule

bind windowed_touch_edge_detector wted_checker u_chk (.*);
